FILE: rtl/core/dbscan_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dbscan_pkg;
	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 10;
	localparam int RAD_W = 21;
	localparam int MINN_W = 7;
	localparam int IDX_W = 6;
	localparam int LBL_W = 7;
	localparam logic [RAD_W-1:0] RAD_RESET = 21'd100;
	localparam logic [MINN_W-1:0] MINN_RESET = 7'd5;
	localparam logic CFG_RADIUS = 1'b0;
	localparam logic CFG_MINN = 1'b1;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SEED,
		ST_CNT_RD,
		ST_CNT,
		ST_CNT_END,
		ST_ABS,
		ST_QPOP,
		ST_QRD,
		ST_OUT_RD,
		ST_OUT,
		ST_CLEAR
	} state_t;

	// neighbour test result from the distance unit
	typedef struct packed {
		logic valid;
		logic hit;
	} dist_res_t;
endpackage
`default_nettype wire

FILE: rtl/core/dbscan_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface dbscan_in_if #(parameter int CB = 10);
	logic valid;
	logic ready;
	logic [CB-1:0] pos_x;
	logic [CB-1:0] pos_y;
	logic final_point;
	modport source(output valid, pos_x, pos_y, final_point, input ready);
	modport sink(input valid, pos_x, pos_y, final_point, output ready);
endinterface

interface dbscan_out_if;
	logic valid;
	logic ready;
	logic [5:0] point_index;
	logic [6:0] cluster_label;
	logic last_label;
	modport source(output valid, point_index, cluster_label, last_label, input ready);
	modport sink(input valid, point_index, cluster_label, last_label, output ready);
endinterface

interface dbscan_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic [20:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/dbscan_point_clustering_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Loading: one point transfer per cycle, stored on the accepting edge.
// After the final point: per visited point a count scan over the N stored points
// through the shared distance unit, an absorb scan over them again for a core point,
// and seed and queue handling; then the labels, each read in ST_OUT_RD and offered
// in ST_OUT, waiting on out_ch.ready; then a clear of marks. Input is held off meanwhile.
// arst_n clears control state and loads default registers; stores need no reset.
module dbscan_point_clustering_unit import dbscan_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	dbscan_in_if.sink  in_ch,
	dbscan_out_if.source out_ch,
	dbscan_cfg_if.sink cfg
);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = AW + 1;
	localparam int LW = (CW > LBL_W) ? CW : LBL_W;
	localparam int NW = (CW > MINN_W) ? CW : MINN_W;

	logic [RAD_W-1:0] rad_q;
	logic [MINN_W-1:0] minn_q;
	state_t st_q, st_d;

	logic [COORD_BITS-1:0] xs [MAX_POINTS];
	logic [COORD_BITS-1:0] ys [MAX_POINTS];
	logic [LW-1:0] lbl [MAX_POINTS];
	logic [AW-1:0] queue [MAX_POINTS];
	logic [MAX_POINTS-1:0] vis_q;

	logic [CW-1:0] cnt_q;      // points stored
	logic [CW-1:0] seed_q;     // outer seed index
	logic [AW-1:0] p_q;        // point under query
	logic [CW-1:0] k_q;        // scan issue index
	logic [CW-1:0] kr_q;       // scan result index
	logic [CW-1:0] head_q, tail_q;
	logic [CW-1:0] ncnt_q;
	logic [LW-1:0] clus_q;
	logic is_seed_q;
	logic fin_q;
	logic [COORD_BITS-1:0] px_q, py_q, kx_q, ky_q;
	logic issue_q;
	logic [AW-1:0] kd_s1, kd_s2, kd_s3;
	logic [AW-1:0] qrd_q;
	logic [LW-1:0] lrd_q;
	logic [AW-1:0] lbl_ra;
	dist_res_t dres;
	logic ovalid_q;
	logic [AW-1:0] oidx_q;
	logic [LBL_W-1:0] olbl_q;
	logic olast_q;

	dbscan_dist #(.CB(COORD_BITS)) u_dist (
		.clk(clk), .arst_n(arst_n), .go(issue_q),
		.ax(px_q), .ay(py_q), .bx(kx_q), .by(ky_q), .rad(rad_q), .res(dres)
	);

	assign cfg.ready = (st_q == ST_LOAD) && !fin_q;
	assign in_ch.ready = (st_q == ST_LOAD) && !fin_q;
	assign out_ch.valid = ovalid_q;
	assign out_ch.point_index = 6'(oidx_q);
	assign out_ch.cluster_label = olbl_q;
	assign out_ch.last_label = olast_q;

	logic scan_last, res_last, core;
	assign scan_last = (k_q + 1'b1 >= cnt_q);
	assign res_last = (kr_q + 1'b1 >= cnt_q);
	assign core = (NW'(ncnt_q) >= NW'(minn_q));
	// label read lines up with the distance result while absorbing
	assign lbl_ra = (st_q == ST_ABS) ? kd_s2 : k_q[AW-1:0];

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_LOAD: if (fin_q) st_d = ST_SEED;
			ST_SEED: begin
				if (seed_q >= cnt_q) st_d = ST_OUT_RD;
				else if (!vis_q[seed_q[AW-1:0]]) st_d = ST_CNT_RD;
				else st_d = ST_SEED;
			end
			ST_CNT_RD: st_d = ST_CNT;
			ST_CNT: if (dres.valid && res_last) st_d = ST_CNT_END;
			ST_CNT_END: begin
				if (!core) st_d = is_seed_q ? ST_SEED : ST_QPOP;
				else st_d = ST_ABS;
			end
			ST_ABS: if (dres.valid && res_last) st_d = ST_QPOP;
			ST_QPOP: st_d = (head_q < tail_q) ? ST_QRD : ST_SEED;
			ST_QRD: st_d = vis_q[qrd_q] ? ST_QPOP : ST_CNT_RD;
			ST_OUT_RD: st_d = ST_OUT;
			ST_OUT: if (!ovalid_q || out_ch.ready)
				st_d = (k_q >= cnt_q) ? ST_CLEAR : ST_OUT_RD;
			ST_CLEAR: if (!ovalid_q && scan_last) st_d = ST_LOAD;
			default: st_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_LOAD;
		else st_q <= st_d;
	end

	// control registers; seed index is CW wide so N itself fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q <= RAD_RESET;
			minn_q <= MINN_RESET;
			cnt_q <= '0;
			seed_q <= '0;
			p_q <= '0;
			k_q <= '0;
			kr_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			ncnt_q <= '0;
			clus_q <= '0;
			is_seed_q <= 1'b0;
			fin_q <= 1'b0;
			vis_q <= '0;
			issue_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			issue_q <= 1'b0;
			if (out_ch.ready) ovalid_q <= 1'b0;
			unique case (st_q)
				ST_LOAD: begin
					if (cfg.valid && cfg.ready) begin
						if (cfg.index == CFG_RADIUS) rad_q <= cfg.data;
						else minn_q <= cfg.data[MINN_W-1:0];
					end
					if (in_ch.valid && in_ch.ready) begin
						if (cnt_q < CW'(MAX_POINTS)) cnt_q <= cnt_q + 1'b1;
						fin_q <= in_ch.final_point;
					end
					seed_q <= '0;
				end
				ST_SEED: begin
					fin_q <= 1'b0;
					if (seed_q < cnt_q) begin
						seed_q <= seed_q + 1'b1;
						if (!vis_q[seed_q[AW-1:0]]) begin
							p_q <= seed_q[AW-1:0];
							vis_q[seed_q[AW-1:0]] <= 1'b1;
							is_seed_q <= 1'b1;
							head_q <= '0;
							tail_q <= '0;
						end
					end
					k_q <= '0;
				end
				ST_CNT_RD: begin
					k_q <= '0;
					kr_q <= '0;
					ncnt_q <= '0;
				end
				ST_CNT: begin
					if (!scan_last || k_q < cnt_q) begin
						if (k_q < cnt_q) begin
							issue_q <= 1'b1;
							k_q <= k_q + 1'b1;
						end
					end
					if (dres.valid) begin
						kr_q <= kr_q + 1'b1;
						if (dres.hit) ncnt_q <= ncnt_q + 1'b1;
					end
				end
				ST_CNT_END: begin
					k_q <= '0;
					kr_q <= '0;
					if (core && is_seed_q) clus_q <= clus_q + 1'b1;
				end
				ST_ABS: begin
					if (k_q < cnt_q) begin
						issue_q <= 1'b1;
						k_q <= k_q + 1'b1;
					end
					if (dres.valid) begin
						kr_q <= kr_q + 1'b1;
						if (dres.hit && lrd_q == '0 && !vis_q[kd_s3]
							&& tail_q < CW'(MAX_POINTS))
							tail_q <= tail_q + 1'b1;
					end
				end
				ST_QPOP: begin
					is_seed_q <= 1'b0;
					if (head_q < tail_q) head_q <= head_q + 1'b1;
					else k_q <= '0;
				end
				ST_QRD: begin
					p_q <= qrd_q;
					if (!vis_q[qrd_q]) vis_q[qrd_q] <= 1'b1;
				end
				ST_OUT_RD: ;
				ST_OUT: begin
					if (!ovalid_q || out_ch.ready) begin
						if (k_q < cnt_q) begin
							ovalid_q <= 1'b1;
							k_q <= k_q + 1'b1;
						end else k_q <= '0;
					end
				end
				ST_CLEAR: begin
					if (!ovalid_q) begin
						vis_q[k_q[AW-1:0]] <= 1'b0;
						k_q <= k_q + 1'b1;
						if (scan_last) begin
							cnt_q <= '0;
							clus_q <= '0;
							k_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// store / memory ports
	always_ff @(posedge clk) begin
		if (st_q == ST_LOAD && in_ch.valid && in_ch.ready && cnt_q < CW'(MAX_POINTS)) begin
			xs[cnt_q[AW-1:0]] <= in_ch.pos_x;
			ys[cnt_q[AW-1:0]] <= in_ch.pos_y;
			lbl[cnt_q[AW-1:0]] <= '0;
		end else if (st_q == ST_CNT_END && core && is_seed_q) begin
			lbl[p_q] <= clus_q + 1'b1;
		end else if (st_q == ST_ABS && dres.valid && dres.hit && lrd_q == '0) begin
			lbl[kd_s3] <= clus_q;
		end
		if (st_q == ST_ABS && dres.valid && dres.hit && lrd_q == '0 && !vis_q[kd_s3]
			&& tail_q < CW'(MAX_POINTS))
			queue[tail_q[AW-1:0]] <= kd_s3;
		px_q <= xs[p_q];
		py_q <= ys[p_q];
		kx_q <= xs[k_q[AW-1:0]];
		ky_q <= ys[k_q[AW-1:0]];
		kd_s1 <= k_q[AW-1:0];
		kd_s2 <= kd_s1;
		kd_s3 <= kd_s2;
		qrd_q <= queue[head_q[AW-1:0]];
		lrd_q <= lbl[lbl_ra];
		if (st_q == ST_OUT && (!ovalid_q || out_ch.ready) && k_q < cnt_q) begin
			oidx_q <= k_q[AW-1:0];
			olbl_q <= LBL_W'(lrd_q);
			olast_q <= scan_last;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/dbscan_dist.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared neighbour test: |dx|,|dy| registered, then squares summed and compared.
module dbscan_dist import dbscan_pkg::*; #(
	parameter int CB = COORD_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic go,
	input  wire logic [CB-1:0] ax,
	input  wire logic [CB-1:0] ay,
	input  wire logic [CB-1:0] bx,
	input  wire logic [CB-1:0] by,
	input  wire logic [RAD_W-1:0] rad,
	output dist_res_t res
);
	// wide enough for the sum of squares and for the radius register
	localparam int DW = (2*CB+1 > RAD_W) ? 2*CB+1 : RAD_W;

	logic [CB-1:0] dx_s1, dy_s1;
	logic v_s1;
	logic [DW-1:0] d2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			res <= '0;
		end else begin
			v_s1 <= go;
			res.valid <= v_s1;
			res.hit <= (d2 != '0) && (d2 <= DW'(rad));
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= (ax > bx) ? ax - bx : bx - ax;
		dy_s1 <= (ay > by) ? ay - by : by - ay;
	end

	assign d2 = DW'(dx_s1 * dx_s1) + DW'(dy_s1 * dy_s1);
endmodule
`default_nettype wire

FILE: rtl/core/dbscan_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module dbscan_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_last
);
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while labels out");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("label dropped");
	a_last_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid)
		else $error("label after last");
endmodule

bind dbscan_point_clustering_unit dbscan_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last_label)
);
`default_nettype wire

FILE: bench/dbscan_point_clustering_unit_test.sv
`timescale 1ns / 1ps
module dbscan_point_clustering_unit_test;
	import dbscan_pkg::*;

	localparam int NPTS = MAX_POINTS_DEF;

	typedef struct packed {
		logic [9:0] x;
		logic [9:0] y;
		logic fin;
	} point_t;

	typedef struct packed {
		logic [5:0] idx;
		logic [6:0] lbl;
		logic last;
	} label_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dbscan_in_if #(.CB(10)) in_ch();
	dbscan_out_if out_ch();
	dbscan_cfg_if cfg();

	dbscan_point_clustering_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg(cfg.sink)
	);

	// predictor state
	logic [20:0] radius_sq = RAD_RESET;
	logic [6:0] min_nb = MINN_RESET;
	logic [9:0] xs[NPTS];
	logic [9:0] ys[NPTS];
	int stored = 0;

	point_t pending_points[$];
	label_t expected_labels[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	bit sender_paused = 0;
	bit in_done = 0;

	function automatic bit near(int a, int b);
		longint dx, dy, d2;
		dx = int'(xs[a]) - int'(xs[b]);
		dy = int'(ys[a]) - int'(ys[b]);
		d2 = dx * dx + dy * dy;
		return d2 != 0 && d2 <= longint'(radius_sq);
	endfunction

	function automatic int degree(int p);
		int n;
		n = 0;
		for (int k = 0; k < stored; k++)
			if (near(p, k))
				n++;
		return n;
	endfunction

	task automatic add_point(point_t p);
		pending_points.insert(pending_points.size(), p);
	endtask

	task automatic cluster_points();
		bit seen[NPTS];
		int lbl[NPTS];
		int fifo[$];
		int clusters, q;
		clusters = 0;
		for (int i = 0; i < NPTS; i++) begin
			seen[i] = 0;
			lbl[i] = 0;
		end
		for (int i = 0; i < stored; i++) begin
			if (seen[i])
				continue;
			seen[i] = 1;
			if (degree(i) < min_nb)
				continue;
			clusters++;
			lbl[i] = clusters;
			fifo.delete();
			q = i;
			forever begin
				// absorb neighbours of q
				for (int k = 0; k < stored; k++) begin
					if (!near(q, k) || lbl[k] != 0)
						continue;
					lbl[k] = clusters;
					if (!seen[k])
						fifo.insert(fifo.size(), k);
				end
				q = -1;
				while (fifo.size() > 0 && q < 0) begin
					q = fifo.pop_front();
					if (seen[q])
						q = -1;
					else begin
						seen[q] = 1;
						if (degree(q) < min_nb)
							q = -1;
					end
				end
				if (q < 0)
					break;
			end
		end
		for (int k = 0; k < stored; k++)
			expected_labels.insert(expected_labels.size(), '{idx: 6'(k),
				lbl: 7'(lbl[k]), last: (k + 1 == stored)});
		stored = 0;
	endtask

	task automatic accept_point(point_t p);
		if (stored < NPTS) begin
			xs[stored] = p.x;
			ys[stored] = p.y;
			stored++;
		end
		if (p.fin)
			cluster_points();
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		in_ch.final_point = 1'b0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_RADIUS;
		cfg.data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && !in_done) begin
				// hold the offered point until its transfer
			end else if (!sender_paused && pending_points.size() > 0
					&& $urandom_range(99) >= send_idle_pct) begin
				in_done = 1'b0;
				in_ch.valid <= 1'b1;
				{in_ch.pos_x, in_ch.pos_y, in_ch.final_point} <= pending_points[0];
			end else begin
				in_done = 1'b0;
				in_ch.valid <= 1'b0;
			end
			if (hold_off > 0)
				out_ch.ready <= 1'b0;
			else
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(negedge clk) begin
		if (hold_off > 0)
			hold_off <= hold_off - 1;
	end

	// monitor
	always @(posedge clk) begin
		label_t got, want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				accept_point(pending_points.pop_front());
				in_done = 1'b1;
			end
			if (out_ch.valid && out_ch.ready) begin
				got = '{idx: out_ch.point_index, lbl: out_ch.cluster_label,
					last: out_ch.last_label};
				if (expected_labels.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected label transfer %p", got);
				end else begin
					want = expected_labels.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("label mismatch: expected %p got %p", want, got);
					end
				end
			end
		end
	end

	task automatic write_reg(logic idx, logic [20:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		if (idx == CFG_RADIUS)
			radius_sq = val;
		else
			min_nb = val[6:0];
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_points.size() > 0 || in_ch.valid || expected_labels.size() > 0)
			@(posedge clk);
		repeat (3 * NPTS + 40) @(posedge clk);
	endtask

	// cluster around a centre with random spread
	task automatic queue_blob(int n, int cx, int cy, int spread, bit fin);
		for (int i = 0; i < n; i++) begin
			point_t p;
			p.x = 10'((cx + $urandom_range(2 * spread) - spread) & 10'h3ff);
			p.y = 10'((cy + $urandom_range(2 * spread) - spread) & 10'h3ff);
			p.fin = fin && (i == n - 1);
			add_point(p);
		end
	endtask

	task automatic queue_set(int n);
		int left, m;
		left = n;
		while (left > 0) begin
			m = (left < 6) ? left : $urandom_range(2, 8);
			if (m > left)
				m = left;
			if ($urandom_range(4) == 0)
				queue_blob(m, $urandom_range(1023), $urandom_range(1023), 512, 0);
			else
				queue_blob(m, $urandom_range(1023), $urandom_range(1023),
					$urandom_range(1, 8), 0);
			left -= m;
		end
		pending_points[$].fin = 1'b1;
	endtask

	initial begin
		int sent;
		@(posedge arst_n);
		// directed: defaults, extremes, coincident points, single point set
		add_point('{x: 10'd0, y: 10'd0, fin: 1'b1});
		for (int i = 0; i < 6; i++)
			add_point('{x: 10'd5, y: 10'd5, fin: 1'b0});
		add_point('{x: 10'h3ff, y: 10'h3ff, fin: 1'b0});
		add_point('{x: 10'h2aa, y: 10'h155, fin: 1'b0});
		add_point('{x: 10'h155, y: 10'h2aa, fin: 1'b1});
		queue_blob(7, 100, 100, 3, 0);
		queue_blob(3, 112, 100, 1, 0);
		queue_blob(6, 140, 100, 3, 1);
		drain();
		write_reg(CFG_RADIUS, 21'h1fffff);
		write_reg(CFG_MINN, 21'd0);
		add_point('{x: 10'd0, y: 10'd0, fin: 1'b0});
		add_point('{x: 10'h3ff, y: 10'h3ff, fin: 1'b0});
		add_point('{x: 10'd0, y: 10'd0, fin: 1'b1});
		drain();
		// store overflow: 70 points, extras dropped
		write_reg(CFG_RADIUS, 21'd50);
		write_reg(CFG_MINN, 21'd2);
		queue_set(70);
		drain();

		sent = 0;
		for (int phase = 0; phase < 8; phase++) begin
			send_idle_pct = (phase % 4 == 1 || phase % 4 == 3) ? 45 : 0;
			recv_stall_pct = (phase % 4 == 2) ? 45 : (phase % 4 == 3 ? 17 : 0);
			if (phase % 4 == 3)
				send_idle_pct = 17;
			case (phase)
				0: begin write_reg(CFG_RADIUS, 21'd0); write_reg(CFG_MINN, 21'd1); end
				2: begin write_reg(CFG_RADIUS, 21'd200); write_reg(CFG_MINN, 21'd64); end
				4: begin write_reg(CFG_RADIUS, 21'd30); write_reg(CFG_MINN, 21'd3); end
				6: begin write_reg(CFG_RADIUS, 21'd500); write_reg(CFG_MINN, 21'd4); end
				default: begin
					write_reg(CFG_RADIUS, 21'($urandom_range(2, 300)));
					write_reg(CFG_MINN, 21'($urandom_range(1, 6)));
				end
			endcase
			if (phase == 5)
				hold_off = 2000;
			for (int s = 0; s < 3; s++) begin
				int n;
				n = $urandom_range(2, 20);
				queue_set(n);
				sent += n;
				if (phase == 3 && s == 0) begin
					// pause the sender until every label of the first set is back
					while (pending_points.size() > 0)
						@(posedge clk);
					sender_paused = 1;
					while (expected_labels.size() > 0 || in_ch.valid)
						@(posedge clk);
					sender_paused = 0;
				end
			end
			drain();
		end
		if (errors == 0)
			$display("dbscan_point_clustering_unit regression: pass");
		else
			$display("dbscan_point_clustering_unit regression: fail");
		$finish;
	end

	initial begin
		#50ms;
		$display("dbscan_point_clustering_unit regression: fail");
		$finish;
	end
endmodule

FILE: dbscan_point_clustering_unit.f
rtl/core/dbscan_pkg.sv
rtl/core/dbscan_if.sv
rtl/core/dbscan_dist.sv
rtl/core/dbscan_point_clustering_unit.sv
rtl/core/dbscan_chk.sv
bench/dbscan_point_clustering_unit_test.sv
